@@ rtl/thist_pkg.sv @@
// Shared widths, register indexes, mode codes and limits of the threshold
// histogram statistics unit. No dependencies; every other file imports it.
package thist_pkg;

    // Field widths of one request record and one result.
    localparam int CODE_W = 10;
    localparam int SIZE_W = 40;
    localparam int DUR_W  = 32;
    localparam int HIT_W  = 3;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;

    // Configuration port.
    localparam int MODE_W     = 3;
    localparam int BINS_W     = 3;
    localparam int BOUND_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int BOUND_REGS = 6;

    // Default for the top-level bin counter depth.
    localparam int DEF_MAX_BINS = 6;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_0     = 3'd2;

    // Report modes.
    localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CODE_HIST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TIME_HIST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SIZE_HIST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SIZE_SUM   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SIZE_AVG   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_TIME_AVG   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 3'd7;

    // Bin count lower limit and reset value.
    localparam logic [BINS_W-1:0] MIN_BINS = 3'd2;

    // Saturation limits.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

@@ rtl/thist_in_if.sv @@
// Request record channel of the threshold histogram statistics unit.
// Depends on thist_pkg for the field widths.
interface thist_in_if
    import thist_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] status_code;
    logic [SIZE_W-1:0] bytes_sent;
    logic [DUR_W-1:0]  duration_us;

    modport source (output valid, output status_code, output bytes_sent,
                    output duration_us, input ready);
    modport sink   (input valid, input status_code, input bytes_sent,
                    input duration_us, output ready);
endinterface

@@ rtl/thist_out_if.sv @@
// Result channel of the threshold histogram statistics unit.
// Depends on thist_pkg for the field widths.
interface thist_out_if
    import thist_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [HIT_W-1:0] bin_hit;
    logic [CNT_W-1:0] bin_total;
    logic [CNT_W-1:0] event_total;
    logic [SUM_W-1:0] value_total;

    modport source (output valid, output bin_hit, output bin_total,
                    output event_total, output value_total, input ready);
    modport sink   (input valid, input bin_hit, input bin_total,
                    input event_total, input value_total, output ready);
endinterface

@@ rtl/threshold_histogram_stats_unit.sv @@
// Top level of the threshold histogram statistics unit: configuration
// registers, record register, update logic and result register.
// Depends on thist_pkg, thist_in_if and thist_out_if.
//
// Usage: software writes report_mode, bin_count_in_use and bound_0..bound_5
// through the plain write port (cfg_we, cfg_index, cfg_data) while the unit
// is idle. Each transaction on the rec channel carries one parsed request
// record; for every record exactly one transaction leaves on the res channel
// with the chosen bin and the updated bin count, event count and running sum
// (fields that do not apply to the mode read as zero).
//
// A record accepted at one clock edge is captured in the record register,
// its update is done by the logic between that register and the result
// register, and the result is then captured in the result register.
// Throughput is one record per cycle while the receiver takes the results;
// it is set by the read-modify-write of the counters (six parallel bound
// compares, two 32-bit saturating increments and one 48-bit saturating add).
//
// Reset clears all counters and the sum, sets report_mode to count mode,
// bin_count_in_use to two and every bound to zero. When the receiver stalls,
// the result register holds its transaction and the record register still
// takes one more record; only then does rec.ready drop.
module threshold_histogram_stats_unit
    import thist_pkg::*;
#(
    parameter int MAX_BINS = DEF_MAX_BINS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    thist_in_if.sink              rec,
    thist_out_if.source           res
);

    // Bins that can ever be chosen: limited by the counters and by the bounds.
    localparam int BIN_LIM = (MAX_BINS < BOUND_REGS) ? MAX_BINS : BOUND_REGS;
    localparam int BIN_W   = $clog2(MAX_BINS);

    // Configuration registers.
    logic [MODE_W-1:0]  mode_reg;
    logic [BINS_W-1:0]  bins_reg;
    logic [BOUND_W-1:0] bound_reg [BOUND_REGS];

    // Statistics state.
    logic [CNT_W-1:0] bin_cnt_reg [MAX_BINS];
    logic [CNT_W-1:0] event_cnt_reg;
    logic [SUM_W-1:0] sum_reg;

    // Record register.
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [CODE_W-1:0] s1_code_reg;
    logic [SIZE_W-1:0] s1_size_reg;
    logic [DUR_W-1:0]  s1_dur_reg;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [HIT_W-1:0] out_hit_reg;
    logic [CNT_W-1:0] out_btot_reg;
    logic [CNT_W-1:0] out_etot_reg;
    logic [SUM_W-1:0] out_vtot_reg;

    // Handshake control.
    logic rec_take;
    logic advance;
    logic update;

    // Update logic.
    logic [BINS_W-1:0]  bins_eff;
    logic [BOUND_W-1:0] val_cmp;
    logic               histo;
    logic [BIN_W-1:0]   bin_sel;
    logic [CNT_W-1:0]   bin_inc;
    logic [CNT_W-1:0]   event_inc;
    logic [SUM_W-1:0]   sum_add;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               do_event;
    logic               do_sum;

    // ------------------------------------------------------------------
    // Handshake: the result register advances when it is empty or taken;
    // the record register takes a new record when it is empty or advancing.
    // ------------------------------------------------------------------
    assign advance   = !out_valid_reg || res.ready;
    assign rec.ready = !s1_valid_reg || advance;
    assign rec_take  = rec.valid && rec.ready;
    assign update    = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rec_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    // ------------------------------------------------------------------
    // Configuration writes.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_COUNT;
            bins_reg <= MIN_BINS;
            for (int i = 0; i < BOUND_REGS; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_REPORT_MODE)
            begin
                mode_reg <= cfg_data[MODE_W-1:0];
            end
            if (cfg_index == CFG_BIN_COUNT)
            begin
                bins_reg <= cfg_data[BINS_W-1:0];
            end
            for (int i = 0; i < BOUND_REGS; i++)
            begin
                if (cfg_index == CFG_BOUND_0 + CFG_IDX_W'(i))
                begin
                    bound_reg[i] <= cfg_data[BOUND_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Update logic: bin choice, saturating increments and the saturating sum.
    // ------------------------------------------------------------------
    always_comb
    begin
        // A bin count outside the usable range is clamped to it.
        if (bins_reg < MIN_BINS)
        begin
            bins_eff = MIN_BINS;
        end
        else if (bins_reg > BINS_W'(BIN_LIM))
        begin
            bins_eff = BINS_W'(BIN_LIM);
        end
        else
        begin
            bins_eff = bins_reg;
        end

        histo    = 1'b0;
        do_event = 1'b0;
        do_sum   = 1'b0;
        val_cmp  = '0;
        sum_add  = '0;
        unique case (mode_reg)
            MODE_COUNT:
            begin
                do_event = 1'b1;
            end
            MODE_CODE_HIST:
            begin
                histo   = 1'b1;
                val_cmp = BOUND_W'(s1_code_reg);
            end
            MODE_TIME_HIST:
            begin
                histo   = 1'b1;
                val_cmp = BOUND_W'(s1_dur_reg);
            end
            MODE_SIZE_HIST:
            begin
                histo   = 1'b1;
                val_cmp = BOUND_W'(s1_size_reg);
            end
            MODE_SIZE_SUM:
            begin
                do_sum  = 1'b1;
                sum_add = SUM_W'(s1_size_reg);
            end
            MODE_SIZE_AVG:
            begin
                do_event = 1'b1;
                do_sum   = 1'b1;
                sum_add  = SUM_W'(s1_size_reg);
            end
            MODE_TIME_AVG:
            begin
                do_event = 1'b1;
                do_sum   = 1'b1;
                sum_add  = SUM_W'(s1_dur_reg);
            end
            default:
            begin
                // The unused mode leaves every statistic alone.
            end
        endcase

        // First bin in order whose bound covers the value; the last active
        // bin when none does. Scanning downward lets the lowest match win.
        bin_sel = BIN_W'(bins_eff - 3'd1);
        for (int i = BIN_LIM - 1; i >= 0; i--)
        begin
            if ((BINS_W'(i) < bins_eff) && (bound_reg[i] >= val_cmp))
            begin
                bin_sel = BIN_W'(i);
            end
        end

        bin_inc   = (bin_cnt_reg[bin_sel] == CNT_MAX) ? CNT_MAX
                                                      : bin_cnt_reg[bin_sel] + 1'b1;
        event_inc = (event_cnt_reg == CNT_MAX) ? CNT_MAX : event_cnt_reg + 1'b1;

        sum_wide = {1'b0, sum_reg} + {1'b0, sum_add};
        sum_sat  = (sum_wide >= {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    // ------------------------------------------------------------------
    // Statistics state and handshake registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            event_cnt_reg <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < MAX_BINS; i++)
            begin
                bin_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (update)
            begin
                if (do_event)
                begin
                    event_cnt_reg <= event_inc;
                end
                if (do_sum)
                begin
                    sum_reg <= sum_sat;
                end
                for (int i = 0; i < MAX_BINS; i++)
                begin
                    if (histo && (bin_sel == BIN_W'(i)))
                    begin
                        bin_cnt_reg[i] <= bin_inc;
                    end
                end
            end
        end
    end

    // Payload registers: record fields and result fields.
    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            s1_code_reg <= rec.status_code;
            s1_size_reg <= rec.bytes_sent;
            s1_dur_reg  <= rec.duration_us;
        end
        if (update)
        begin
            out_hit_reg  <= histo ? HIT_W'(bin_sel) : '0;
            out_btot_reg <= histo ? bin_inc : '0;
            out_etot_reg <= do_event ? event_inc : '0;
            out_vtot_reg <= do_sum ? sum_sat : '0;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.bin_hit     = out_hit_reg;
    assign res.bin_total   = out_btot_reg;
    assign res.event_total = out_etot_reg;
    assign res.value_total = out_vtot_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The record side only stalls when both registers hold a transaction.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !rec.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("record channel stalled while a register was free");

    // A record in the unused mode produces an all-zero result.
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (update && (mode_reg == MODE_UNUSED)) |=>
        (res.bin_hit == '0 && res.bin_total == '0 &&
         res.event_total == '0 && res.value_total == '0))
        else $error("unused mode produced a nonzero result");

    // Count mode below saturation advances the event counter by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (update && (mode_reg == MODE_COUNT) && (event_cnt_reg != CNT_MAX)) |=>
        (event_cnt_reg == $past(event_cnt_reg) + 1'b1))
        else $error("event counter did not advance by one in count mode");

endmodule
